### design/sorted_key_value_table_assert.svh
// Assertion macros used by the sorted_key_value_table module.
`ifndef SORTED_KEY_VALUE_TABLE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_ASSERT_SVH

// Implication checked on every clock edge while out of reset.
`define SKV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/skv_pkg.sv
`timescale 1ns / 1ps
package skv_pkg;
    localparam int TableDepth = 1024;
    localparam int AddrW = $clog2(TableDepth);
    localparam int CountW = AddrW + 1;

    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_ADD = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [1:0] REG_CAPACITY = 2'd0;

    localparam int EntryW = 96;

    typedef struct packed {
        logic [1:0] cmd;
        logic signed [31:0] key;
        logic signed [63:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] read_value;
        logic [1:0] status;
        logic [10:0] fill_count;
    } t_out_item;
endpackage

### design/skv_ram.sv
`timescale 1ns / 1ps
module skv_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/sorted_key_value_table.sv
// A get runs a binary search over the sorted entries and then returns its result;
// an add or remove also shifts the later entries by one slot, one entry at a time.
// Only one transaction is in flight at a time; a new one is accepted only in idle.
// The memory is one 96-bit wide RAM holding key and value per entry.
// Reset clears the fill count, restores capacity_limit to 1024, and leaves
// the memory contents undefined; no clearing pass is needed.
`timescale 1ns / 1ps
module sorted_key_value_table (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  skv_pkg::t_in_item       i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output skv_pkg::t_out_item      o_out_data,
    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic [1:0]              i_paddr,
    input  logic [31:0]             i_pwdata,
    output logic [31:0]             o_prdata,
    output logic                    o_pready
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_SWAIT = 7'b0000100,
        S_DEC   = 7'b0001000,
        S_MREAD = 7'b0010000,
        S_MWR   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    skv_pkg::t_in_item r_item, n_item;
    logic [skv_pkg::CountW-1:0] r_count, n_count;
    logic [10:0] r_cap, n_cap;
    logic [skv_pkg::CountW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [skv_pkg::CountW-1:0] r_ptr, n_ptr;
    logic r_up, n_up;
    logic r_out_valid, n_out_valid;
    skv_pkg::t_out_item r_out, n_out;
    skv_pkg::t_out_item r_res, n_res;

    logic we;
    logic [skv_pkg::AddrW-1:0] waddr, raddr;
    logic [skv_pkg::EntryW-1:0] wdata, rdata;
    logic [skv_pkg::CountW-1:0] mid, eff_cap;
    logic [31:0] bk, rk;
    logic cfg_wr;

    skv_ram #(.Width(skv_pkg::EntryW), .Depth(skv_pkg::TableDepth)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign cfg_wr = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_prdata = {21'd0, r_cap};
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;
    assign mid = r_lo + ((r_hi - r_lo) >> 1);
    assign bk = r_item.key ^ 32'h8000_0000;
    assign rk = rdata[95:64] ^ 32'h8000_0000;
    assign eff_cap = (r_cap > 11'(skv_pkg::TableDepth))
                   ? skv_pkg::CountW'(skv_pkg::TableDepth)
                   : skv_pkg::CountW'(r_cap);

    always_comb begin
        n_state = r_state;
        n_item = r_item;
        n_count = r_count;
        n_cap = r_cap;
        n_lo = r_lo;
        n_hi = r_hi;
        n_ptr = r_ptr;
        n_up = r_up;
        n_out_valid = r_out_valid;
        n_out = r_out;
        n_res = r_res;
        we = 1'b0;
        waddr = r_ptr[skv_pkg::AddrW-1:0];
        wdata = rdata;
        raddr = mid[skv_pkg::AddrW-1:0];
        if (cfg_wr && i_paddr == skv_pkg::REG_CAPACITY) begin
            n_cap = i_pwdata[10:0];
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    n_lo = '0;
                    n_hi = r_count;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = S_SWAIT;
                end else begin
                    raddr = r_lo[skv_pkg::AddrW-1:0];
                    n_state = S_DEC;
                end
            end
            S_SWAIT: begin
                if (rk < bk) begin
                    n_lo = mid + 1'b1;
                end else begin
                    n_hi = mid;
                end
                n_state = S_SRCH;
            end
            S_DEC: begin
                n_res.read_value = '1;
                n_res.status = skv_pkg::ST_OK;
                n_state = S_OUT;
                unique case (r_item.cmd)
                    skv_pkg::CMD_GET: begin
                        if (r_lo < r_count && rk == bk) begin
                            n_res.read_value = rdata[63:0];
                        end else begin
                            n_res.status = skv_pkg::ST_NOT_FOUND;
                        end
                    end
                    skv_pkg::CMD_ADD: begin
                        if (r_count >= eff_cap) begin
                            n_res.status = skv_pkg::ST_FULL;
                        end else if (r_lo < r_count && rk == bk) begin
                            n_res.status = skv_pkg::ST_DUPLICATE;
                        end else begin
                            n_up = 1'b1;
                            n_ptr = r_count;
                            n_state = S_MREAD;
                        end
                    end
                    skv_pkg::CMD_REMOVE: begin
                        if (r_lo < r_count && rk == bk) begin
                            n_up = 1'b0;
                            n_ptr = r_lo;
                            n_state = S_MREAD;
                        end else begin
                            n_res.status = skv_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MREAD: begin
                if (r_up) begin
                    if (r_ptr == r_lo) begin
                        we = 1'b1;
                        wdata = {bk ^ 32'h8000_0000, r_item.entry_value};
                        n_count = r_count + 1'b1;
                        n_state = S_OUT;
                    end else begin
                        raddr = skv_pkg::AddrW'(r_ptr - 1'b1);
                        n_state = S_MWR;
                    end
                end else begin
                    if (r_ptr + 1'b1 >= r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = S_OUT;
                    end else begin
                        raddr = skv_pkg::AddrW'(r_ptr + 1'b1);
                        n_state = S_MWR;
                    end
                end
            end
            S_MWR: begin
                we = 1'b1;
                n_ptr = r_up ? r_ptr - 1'b1 : r_ptr + 1'b1;
                n_state = S_MREAD;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out = r_res;
                    n_out.fill_count = 11'(n_count);
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap <= 11'd1024;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cap <= n_cap;
            r_out_valid <= n_out_valid;
        end
        r_item <= n_item;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_ptr <= n_ptr;
        r_up <= n_up;
        r_out <= n_out;
        r_res <= n_res;
    end

`include "sorted_key_value_table_assert.svh"
    `SKV_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1,
        r_count <= skv_pkg::CountW'(skv_pkg::TableDepth))
    `SKV_ASSERT_IMP(a_search_bounds, i_clk, i_rst_n, r_state == S_SWAIT,
        r_lo < r_hi && r_hi <= r_count)
    `SKV_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, r_state != S_MREAD,
        r_count == $past(r_count))
    `SKV_ASSERT_IMP(a_write_only_shift, i_clk, i_rst_n, we,
        r_state == S_MWR || r_state == S_MREAD)
endmodule
